/* rtl/core/pixel_brightness_contrast_saturation_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the brightness / contrast / saturation block
// Clocked assertion forms used by the checker file bcs_checker.sv.
// ----------------------------------------------------------------------------
`ifndef PIXEL_BRIGHTNESS_CONTRAST_SATURATION_TOP_ASSERT_SVH
`define PIXEL_BRIGHTNESS_CONTRAST_SATURATION_TOP_ASSERT_SVH

// checked only outside reset
`define BCS_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked on every edge, reset included
`define BCS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/bcs_pkg.sv */
// ----------------------------------------------------------------------------
// bcs_pkg
// Types and constants of the brightness / contrast / saturation pipeline.
// ----------------------------------------------------------------------------
package bcs_pkg;

    localparam int BRIGHT_BITS    = 9;
    localparam int GAIN_BITS      = 10;
    localparam int GAIN_ONE       = 256;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam int NUM_COLOR = 3;
    localparam int NSTAGE    = 6;

    // BT.601 luma weights, 8 fraction bits
    localparam int W_RED   = 77;
    localparam int W_GREEN = 150;
    localparam int W_BLUE  = 29;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BRIGHTNESS = 2'd0,
        CFG_CONTRAST   = 2'd1,
        CFG_SATURATION = 2'd2
    } bcs_cfg_reg_t;

    typedef struct packed {
        logic d_load;
        logic u_load;
    } bcs_front_ctl_t;

endpackage

/* rtl/core/bcs_contrast.sv */
// ----------------------------------------------------------------------------
// bcs_contrast
// Front two stages of one color channel: brightness offset about mid-grey,
// then the contrast gain. Output u carries 9 fraction bits.
// ----------------------------------------------------------------------------
module bcs_contrast #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                      aclk,
    input  bcs_pkg::bcs_front_ctl_t                   ctl,
    input  logic [CHANNEL_BITS-1:0]                   chan_in,
    input  logic signed [bcs_pkg::BRIGHT_BITS-1:0]    brightness,
    input  logic [bcs_pkg::GAIN_BITS-1:0]             contrast,
    output logic signed [CHANNEL_BITS+13:0]           u_out
);
    import bcs_pkg::*;

    localparam int DW   = CHANNEL_BITS + 3;
    localparam int UW   = CHANNEL_BITS + 14;
    localparam int MAXV = (1 << CHANNEL_BITS) - 1;

    logic signed [DW-1:0] chan_ext;
    logic signed [DW-1:0] sum;
    logic signed [DW-1:0] d_next;
    logic signed [DW-1:0] d_reg;
    logic signed [UW-1:0] u_next;
    logic signed [UW-1:0] u_reg;

    // d = 2*(c + b) - MAXV, mid-grey is MAXV/2
    always_comb begin
        chan_ext = $signed({3'b000, chan_in});
        sum      = chan_ext + DW'(brightness);
        d_next   = (sum <<< 1) - DW'(MAXV);
    end

    assign u_next = UW'(d_reg) * UW'($signed({1'b0, contrast})) + UW'(MAXV * GAIN_ONE);

    always_ff @(posedge aclk) begin
        if (ctl.d_load) begin
            d_reg <= d_next;
        end
        if (ctl.u_load) begin
            u_reg <= u_next;
        end
    end

    assign u_out = u_reg;

endmodule

/* rtl/core/pixel_brightness_contrast_saturation_top.sv */
// ----------------------------------------------------------------------------
// pixel_brightness_contrast_saturation_top
// Brightness, contrast and BT.601-luma saturation adjust of RGBA pixels.
// ----------------------------------------------------------------------------
// One pixel per clock in, one per clock out while the output does not stall.
// Six register stages (offset, contrast multiply, luma sum, luma difference,
// saturation multiply, round and clamp) each hold their own valid bit; a
// per-stage ready chain lets bubbles close up under an output stall, so input
// is taken whenever any stage is free. Configuration writes are always
// accepted and act at once on every pixel that has not yet passed the stage
// reading that register, so write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
module pixel_brightness_contrast_saturation_top #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [bcs_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bcs_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [CHANNEL_BITS-1:0]              s_red_in,
    input  logic [CHANNEL_BITS-1:0]              s_green_in,
    input  logic [CHANNEL_BITS-1:0]              s_blue_in,
    input  logic [CHANNEL_BITS-1:0]              s_alpha_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [CHANNEL_BITS-1:0]              m_red_out,
    output logic [CHANNEL_BITS-1:0]              m_green_out,
    output logic [CHANNEL_BITS-1:0]              m_blue_out,
    output logic [CHANNEL_BITS-1:0]              m_alpha_out
);
    import bcs_pkg::*;

    localparam int CB    = CHANNEL_BITS;
    localparam int UW    = CB + 14;
    localparam int YW    = UW + 8;
    localparam int EW    = YW + 2;
    localparam int MW    = EW + 11;
    localparam int PW    = MW + 1;
    localparam int MAXV  = (1 << CB) - 1;
    localparam int RND   = 1 << 24;
    localparam int SHIFT = 25;

    // configuration
    logic signed [BRIGHT_BITS-1:0] brightness_reg;
    logic [GAIN_BITS-1:0]          contrast_reg;
    logic [GAIN_BITS-1:0]          saturation_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= '0;
            contrast_reg   <= GAIN_BITS'(GAIN_ONE);
            saturation_reg <= GAIN_BITS'(GAIN_ONE);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_BRIGHTNESS: brightness_reg <= cfg_wdata[BRIGHT_BITS-1:0];
                CFG_CONTRAST:   contrast_reg   <= cfg_wdata[GAIN_BITS-1:0];
                CFG_SATURATION: saturation_reg <= cfg_wdata[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage control
    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_in;
    logic [NSTAGE:0]   adv;

    always_comb begin
        adv[NSTAGE] = m_ready;
        for (int i = NSTAGE - 1; i >= 0; i--) begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    assign valid_in = {valid_reg[NSTAGE-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NSTAGE; i++) begin
                if (adv[i]) begin
                    valid_reg[i] <= valid_in[i];
                end
            end
        end
    end

    assign s_ready = adv[0];
    assign m_valid = valid_reg[NSTAGE-1];

    // alpha delay line
    logic [CB-1:0] alpha_reg [NSTAGE];

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NSTAGE; i++) begin
            if (adv[i]) begin
                alpha_reg[i] <= (i == 0) ? s_alpha_in : alpha_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    // stages 0 and 1: offset and contrast
    bcs_front_ctl_t       front_ctl;
    logic [CB-1:0]        chan_in [NUM_COLOR];
    logic signed [UW-1:0] u_ch    [NUM_COLOR];

    assign front_ctl.d_load = adv[0];
    assign front_ctl.u_load = adv[1];
    assign chan_in[0] = s_red_in;
    assign chan_in[1] = s_green_in;
    assign chan_in[2] = s_blue_in;

    for (genvar c = 0; c < NUM_COLOR; c++) begin : g_front
        bcs_contrast #(
            .CHANNEL_BITS (CB)
        ) u_contrast (
            .aclk       (aclk),
            .ctl        (front_ctl),
            .chan_in    (chan_in[c]),
            .brightness (brightness_reg),
            .contrast   (contrast_reg),
            .u_out      (u_ch[c])
        );
    end

    // stage 2: luma
    logic signed [YW-1:0] y_next;
    logic signed [YW-1:0] y2_reg;
    logic signed [UW-1:0] u2_reg [NUM_COLOR];

    assign y_next = YW'(u_ch[0]) * YW'(W_RED) + YW'(u_ch[1]) * YW'(W_GREEN)
                  + YW'(u_ch[2]) * YW'(W_BLUE);

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            y2_reg <= y_next;
            for (int c = 0; c < NUM_COLOR; c++) begin
                u2_reg[c] <= u_ch[c];
            end
        end
    end

    // stage 3: channel minus luma
    logic signed [EW-1:0] e_next [NUM_COLOR];
    logic signed [EW-1:0] e3_reg [NUM_COLOR];
    logic signed [YW-1:0] y3_reg;

    always_comb begin
        for (int c = 0; c < NUM_COLOR; c++) begin
            e_next[c] = (EW'(u2_reg[c]) <<< 8) - EW'(y2_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            y3_reg <= y2_reg;
            for (int c = 0; c < NUM_COLOR; c++) begin
                e3_reg[c] <= e_next[c];
            end
        end
    end

    // stage 4: saturation multiply
    logic signed [MW-1:0] m_next [NUM_COLOR];
    logic signed [MW-1:0] m4_reg [NUM_COLOR];
    logic signed [YW-1:0] y4_reg;

    always_comb begin
        for (int c = 0; c < NUM_COLOR; c++) begin
            m_next[c] = MW'(e3_reg[c]) * MW'($signed({1'b0, saturation_reg}));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            y4_reg <= y3_reg;
            for (int c = 0; c < NUM_COLOR; c++) begin
                m4_reg[c] <= m_next[c];
            end
        end
    end

    // stage 5: round half up and clamp
    logic signed [PW-1:0] p_sum  [NUM_COLOR];
    logic signed [PW-1:0] q_val  [NUM_COLOR];
    logic [CB-1:0]        o_next [NUM_COLOR];
    logic [CB-1:0]        o5_reg [NUM_COLOR];

    always_comb begin
        for (int c = 0; c < NUM_COLOR; c++) begin
            p_sum[c] = PW'(m4_reg[c]) + (PW'(y4_reg) <<< 8) + PW'(RND);
            q_val[c] = p_sum[c] >>> SHIFT;
            if (q_val[c][PW-1]) begin
                o_next[c] = '0;
            end else if (q_val[c] > PW'(MAXV)) begin
                o_next[c] = CB'(MAXV);
            end else begin
                o_next[c] = q_val[c][CB-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            for (int c = 0; c < NUM_COLOR; c++) begin
                o5_reg[c] <= o_next[c];
            end
        end
    end

    assign m_red_out   = o5_reg[0];
    assign m_green_out = o5_reg[1];
    assign m_blue_out  = o5_reg[2];
    assign m_alpha_out = alpha_reg[NSTAGE-1];

endmodule

/* rtl/core/bcs_checker.sv */
// ----------------------------------------------------------------------------
// bcs_checker
// Port-level checks of the brightness / contrast / saturation pipeline.
// ----------------------------------------------------------------------------
`include "pixel_brightness_contrast_saturation_top_assert.svh"

module bcs_checker #(
    parameter int CHANNEL_BITS = 8
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [CHANNEL_BITS-1:0] s_alpha_in,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [CHANNEL_BITS-1:0] m_alpha_out
);

    `BCS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "output valid after reset")

    `BCS_ASSERT(a_ready_flow, aclk, aresetn, m_ready |-> s_ready, "input blocked while output drains")

    `BCS_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "output dropped before transfer")

    `BCS_ASSERT(a_alpha_latency, aclk, aresetn, (s_valid && s_ready && m_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready |=> m_valid && (m_alpha_out == $past(s_alpha_in, 6)), "alpha not delivered after six cycles")

endmodule

bind pixel_brightness_contrast_saturation_top bcs_checker #(
    .CHANNEL_BITS (CHANNEL_BITS)
) u_bcs_checker (.*);

/* dv/pixel_brightness_contrast_saturation_top_test.sv */
// ----------------------------------------------------------------------------
// pixel_brightness_contrast_saturation_top_test
// Self-checking bench for the brightness / contrast / saturation pipeline.
// A directed table covers the identity setting, the offset and gain extremes,
// ignored register bits and the unused register index. Random pixels follow
// under changing register settings and three idle patterns, with one long
// output hold-off that backs the pipeline up. Every output transfer is checked
// field by field against the table's result or an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module pixel_brightness_contrast_saturation_top_test;

    import bcs_pkg::*;

    localparam int     CH_W           = 8;
    localparam longint MAXV           = 255;
    localparam longint LUMA_WR        = 77;
    localparam longint LUMA_WG        = 150;
    localparam longint LUMA_WB        = 29;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam int     HOLD_CYCLES    = 64;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 20;
    localparam int     CHUNK_PIXELS   = 60;
    localparam int     CHUNKS         = 5;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic                      is_write;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  wdata;
        pixel_t                    pix;
        logic                      known;
        pixel_t                    result;
    } dir_row_t;

    function automatic dir_row_t cfg_row(logic [CFG_INDEX_BITS-1:0] idx,
                                         logic [CFG_DATA_BITS-1:0] data);
        return '{is_write: 1'b1, index: idx, wdata: data, pix: '0, known: 1'b0,
                 result: '0};
    endfunction

    function automatic dir_row_t pix_row(pixel_t pix);
        return '{is_write: 1'b0, index: '0, wdata: '0, pix: pix, known: 1'b0,
                 result: '0};
    endfunction

    function automatic dir_row_t known_row(pixel_t pix, pixel_t res);
        return '{is_write: 1'b0, index: '0, wdata: '0, pix: pix, known: 1'b1,
                 result: res};
    endfunction

    localparam int N_DIR = 32;
    localparam dir_row_t DIRECTED [N_DIR] = '{
        known_row(32'h00000000, 32'h00000000),
        known_row(32'hFFFFFFFF, 32'hFFFFFFFF),
        known_row(32'h55AA1280, 32'h55AA1280),
        known_row(32'hAA55ED7F, 32'hAA55ED7F),
        cfg_row(CFG_UNUSED, 16'hFFFF),
        known_row(32'h01FE8000, 32'h01FE8000),
        cfg_row(CFG_BRIGHTNESS, 16'h00FF),
        known_row(32'h0080FF01, 32'hFFFFFF01),
        cfg_row(CFG_BRIGHTNESS, 16'hFF01),
        known_row(32'hFFFFFFFE, 32'h000000FE),
        cfg_row(CFG_BRIGHTNESS, 16'h0100),
        known_row(32'hFF007F33, 32'h00000033),
        cfg_row(CFG_BRIGHTNESS, 16'hAE00),
        cfg_row(CFG_CONTRAST, 16'h0000),
        known_row(32'h00FF4D44, 32'h80808044),
        cfg_row(CFG_CONTRAST, 16'h0300),
        pix_row(32'h40C09055),
        cfg_row(CFG_CONTRAST, 16'hFFFF),
        pix_row(32'h708F80AA),
        cfg_row(CFG_CONTRAST, 16'h0100),
        cfg_row(CFG_SATURATION, 16'h0000),
        pix_row(32'hFF000012),
        cfg_row(CFG_SATURATION, 16'h0300),
        pix_row(32'h20C06034),
        cfg_row(CFG_SATURATION, 16'hFC00 | 16'h03FF),
        pix_row(32'h9A40C8FF),
        cfg_row(CFG_BRIGHTNESS, 16'h019C),
        cfg_row(CFG_CONTRAST, 16'h0300),
        cfg_row(CFG_SATURATION, 16'h0000),
        pix_row(32'hC8641000),
        cfg_row(CFG_BRIGHTNESS, 16'h00FF),
        pix_row(32'h7F8081C3)
    };

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    logic [CH_W-1:0]           s_red_in   = '0;
    logic [CH_W-1:0]           s_green_in = '0;
    logic [CH_W-1:0]           s_blue_in  = '0;
    logic [CH_W-1:0]           s_alpha_in = '0;
    logic                      m_valid;
    logic                      m_ready    = 1'b0;
    logic [CH_W-1:0]           m_red_out;
    logic [CH_W-1:0]           m_green_out;
    logic [CH_W-1:0]           m_blue_out;
    logic [CH_W-1:0]           m_alpha_out;

    logic signed [BRIGHT_BITS-1:0] bright_reg   = '0;
    logic [GAIN_BITS-1:0]          contrast_reg = GAIN_BITS'(GAIN_ONE);
    logic [GAIN_BITS-1:0]          sat_reg      = GAIN_BITS'(GAIN_ONE);

    pixel_t adjusted_q [$];
    int     bad_pixels   = 0;
    int     tx_idle_pct  = 14;
    int     rx_idle_pct  = 54;
    logic   hold_req     = 1'b0;
    logic   hold_done    = 1'b0;
    int     hold_left    = 0;
    int     stall_cycles = 0;

    pixel_brightness_contrast_saturation_top #(
        .CHANNEL_BITS (CH_W)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_red_in    (s_red_in),
        .s_green_in  (s_green_in),
        .s_blue_in   (s_blue_in),
        .s_alpha_in  (s_alpha_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_red_out   (m_red_out),
        .m_green_out (m_green_out),
        .m_blue_out  (m_blue_out),
        .m_alpha_out (m_alpha_out)
    );

    always #10 aclk = ~aclk;

    // channel after offset and contrast, 16 fraction bits
    function automatic longint contrast_scale(logic [CH_W-1:0] c);
        longint a;
        a = (longint'(c) + longint'(bright_reg)) * 256;
        return (a - MAXV * 128) * longint'(contrast_reg) + MAXV * 32768;
    endfunction

    // saturation mix about luma, then round half up and clamp
    function automatic logic [CH_W-1:0] saturate_mix(longint v, longint luma);
        longint o;
        o = luma * 256 + (v * 256 - luma) * longint'(sat_reg) + (longint'(1) <<< 31);
        if (o < 0)
            return '0;
        if ((o >>> 32) > MAXV)
            return CH_W'(MAXV);
        return CH_W'(o >>> 32);
    endfunction

    function automatic pixel_t adjust_pixel(pixel_t pix);
        longint vr, vg, vb, luma;
        pixel_t res;
        vr   = contrast_scale(pix.red);
        vg   = contrast_scale(pix.green);
        vb   = contrast_scale(pix.blue);
        luma = LUMA_WR * vr + LUMA_WG * vg + LUMA_WB * vb;
        res.red   = saturate_mix(vr, luma);
        res.green = saturate_mix(vg, luma);
        res.blue  = saturate_mix(vb, luma);
        res.alpha = pix.alpha;
        return res;
    endfunction

    function automatic logic [GAIN_BITS-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return GAIN_BITS'(768);
            2: return GAIN_BITS'($urandom_range(769, 1023));
            3: return GAIN_BITS'(GAIN_ONE);
            default: return GAIN_BITS'($urandom_range(0, 768));
        endcase
    endfunction

    // register writes only once the pipeline has drained
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        s_valid <= 1'b0;
        while (adjusted_q.size() != 0)
            @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_BRIGHTNESS: bright_reg   = data[BRIGHT_BITS-1:0];
            CFG_CONTRAST:   contrast_reg = data[GAIN_BITS-1:0];
            CFG_SATURATION: sat_reg      = data[GAIN_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(input pixel_t pix, input logic known, input pixel_t res);
        cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_red_in   <= pix.red;
        s_green_in <= pix.green;
        s_blue_in  <= pix.blue;
        s_alpha_in <= pix.alpha;
        do @(posedge aclk); while (!s_ready);
        adjusted_q.push_back(known ? res : adjust_pixel(pix));
    endtask

    task automatic check_field(input string name, input logic [CH_W-1:0] want,
                               input logic [CH_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            bad_pixels++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_out
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (adjusted_q.size() == 0) begin
                $error("output transfer with no pixel pending");
                bad_pixels++;
            end else begin
                want = adjusted_q.pop_front();
                check_field("red_out", want.red, m_red_out);
                check_field("green_out", want.green, m_green_out);
                check_field("blue_out", want.blue, m_blue_out);
                check_field("alpha_out", want.alpha, m_alpha_out);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("[pixel_brightness_contrast_saturation_top] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        dir_row_t                 row;
        pixel_t                   pix;
        logic [CFG_DATA_BITS-1:0] data;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            row = DIRECTED[i];
            if (row.is_write)
                write_reg(row.index, row.wdata);
            else
                send_pixel(row.pix, row.known, row.result);
        end

        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 54 : 0;
            rx_idle_pct <= (ph == 0) ? 54 : (ph == 1) ? 14 : 0;
            for (int chunk = 0; chunk < CHUNKS; chunk++) begin
                data = CFG_DATA_BITS'($urandom);
                case ($urandom_range(0, 5))
                    0: data[BRIGHT_BITS-1:0] = 9'h0FF;
                    1: data[BRIGHT_BITS-1:0] = 9'h101;
                    2: data[BRIGHT_BITS-1:0] = 9'h000;
                    3: data[BRIGHT_BITS-1:0] = 9'h100;
                    default: data[BRIGHT_BITS-1:0] = BRIGHT_BITS'($urandom);
                endcase
                write_reg(CFG_BRIGHTNESS, data);
                data = CFG_DATA_BITS'($urandom);
                data[GAIN_BITS-1:0] = pick_gain();
                write_reg(CFG_CONTRAST, data);
                data = CFG_DATA_BITS'($urandom);
                data[GAIN_BITS-1:0] = pick_gain();
                write_reg(CFG_SATURATION, data);
                if ($urandom_range(0, 3) == 0)
                    write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom));
                // long output hold-off while input keeps flowing
                if (ph == 2 && chunk == 0)
                    hold_req <= 1'b1;
                repeat (CHUNK_PIXELS) begin
                    pix = pixel_t'($urandom);
                    case ($urandom_range(0, 9))
                        0: begin
                            pix.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                            pix.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                            pix.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                        end
                        1: begin
                            pix.green = pix.red;
                            pix.blue  = pix.red;
                        end
                        default: ;
                    endcase
                    send_pixel(pix, 1'b0, '0);
                end
            end
        end

        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        while (adjusted_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (bad_pixels == 0)
            $display("[pixel_brightness_contrast_saturation_top] OK");
        else
            $display("[pixel_brightness_contrast_saturation_top] ERROR");
        $finish;
    end

endmodule
